// ===== rtl/core/lzse_pkg.sv =====
// ----------------------------------------------------------------------------
// lzse_pkg
// Shared constants, types and elaboration helpers for the LZ77 stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lzse_pkg;

    localparam int DEF_WINDOW    = 4095;
    localparam int DEF_MAX_MATCH = 255;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 8;
    localparam int OFFSET_W = 12;

    // reduction tree over the cell row
    localparam int TREE_FANIN = 16;
    localparam int FAN_BITS   = 4;

    typedef struct packed {
        logic step;     // commit the current item into the row
        logic extend;   // item extends the open match
    } cell_ctl_t;

    function automatic int pow_int(input int base, input int e);
        int r;
        r = 1;
        for (int i = 0; i < 32; i++) begin
            if (i < e) begin
                r = r * base;
            end
        end
        return r;
    endfunction

    // number of tree levels needed to cover n leaves
    function automatic int tree_levels(input int n, input int fan);
        int lv;
        int cap;
        lv  = 1;
        cap = fan;
        for (int i = 0; i < 32; i++) begin
            if (cap < n) begin
                cap = cap * fan;
                lv  = lv + 1;
            end
        end
        return lv;
    endfunction

    // first flat index of tree level l (level 0 holds the leaves)
    function automatic int level_base(input int l, input int levels, input int fan);
        int sum;
        sum = 0;
        for (int k = 0; k < 33; k++) begin
            if (k < l && k <= levels) begin
                sum = sum + pow_int(fan, levels - k);
            end
        end
        return sum;
    endfunction

    function automatic int idx_width(input int levels);
        int w;
        w = levels * FAN_BITS;
        if (w < OFFSET_W) begin
            w = OFFSET_W;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lz77_stream_encoder_core.sv =====
// ----------------------------------------------------------------------------
// lz77_stream_encoder_core
// Greedy LZ77 encoder built as a row of window cells with a max/OR tree.
// ----------------------------------------------------------------------------
// One cell per offset holds the byte that many positions back and a live
// flag. An item is taken into the byte register, passes through the LEVELS
// (LEVELS = ceil(log16(WINDOW+1)), WINDOW 4095 by default) registered levels
// of the 16-way tree that finds the highest live offset and any match over
// the cell row, and is then committed, which shifts the row and loads the
// token. A byte that extends the match commits at once. A token still waiting
// on out_ready holds the commit of the next token, and the input with it. The
// final byte always closes the match as the literal.
`default_nettype none

module lz77_stream_encoder_core
    import lzse_pkg::*;
#(
    parameter int WINDOW    = DEF_WINDOW,
    parameter int MAX_MATCH = DEF_MAX_MATCH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [BYTE_W-1:0]   data_byte,
    input  wire logic                last,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [OFFSET_W-1:0] offset,
    output logic      [LEN_W-1:0]    length,
    output logic      [BYTE_W-1:0]   next_byte
);

    localparam int LEVELS = tree_levels(WINDOW + 1, TREE_FANIN);
    localparam int PAD    = pow_int(TREE_FANIN, LEVELS);
    localparam int IDXW   = idx_width(LEVELS);
    localparam int TOTAL  = level_base(LEVELS + 1, LEVELS, TREE_FANIN);
    localparam int ROOT   = level_base(LEVELS, LEVELS, TREE_FANIN);
    localparam int CNT_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_MATCH);
    localparam logic [CNT_W-1:0] LAST_LVL = CNT_W'(LEVELS - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_REDUCE = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [OFFSET_W-1:0] offset_reg;
    logic [LEN_W-1:0]    length_reg;
    logic [BYTE_W-1:0]   next_byte_reg;

    logic      in_take;
    logic      extend;
    logic      commit_go;
    cell_ctl_t ctl;

    logic [BYTE_W-1:0] row_byte   [0:WINDOW];
    logic              row_filled [0:WINDOW];
    logic              cell_alive [1:WINDOW];
    logic              cell_hit   [1:WINDOW];

    logic            node_alive [0:TOTAL-1];
    logic            node_hit   [0:TOTAL-1];
    logic [IDXW-1:0] node_idx   [0:TOTAL-1];

    // ------------------------------------------------------------------
    // cell row
    // ------------------------------------------------------------------
    assign row_byte[0]   = byte_reg;
    assign row_filled[0] = 1'b1;

    for (genvar d = 1; d <= WINDOW; d++)
    begin : g_cell
        lzse_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .cmp_byte    (byte_reg),
            .prev_byte   (row_byte[d-1]),
            .prev_filled (row_filled[d-1]),
            .hist_byte   (row_byte[d]),
            .filled      (row_filled[d]),
            .alive       (cell_alive[d]),
            .hit         (cell_hit[d])
        );
    end

    // ------------------------------------------------------------------
    // leaves and reduction tree
    // ------------------------------------------------------------------
    for (genvar i = 0; i < PAD; i++)
    begin : g_leaf
        if (i >= 1 && i <= WINDOW)
        begin : g_used
            assign node_alive[i] = cell_alive[i];
            assign node_hit[i]   = cell_hit[i];
            assign node_idx[i]   = IDXW'(i);
        end
        else
        begin : g_pad
            assign node_alive[i] = 1'b0;
            assign node_hit[i]   = 1'b0;
            assign node_idx[i]   = '0;
        end
    end

    for (genvar l = 1; l <= LEVELS; l++)
    begin : g_lvl
        localparam int NODES    = pow_int(TREE_FANIN, LEVELS - l);
        localparam int BASE     = level_base(l, LEVELS, TREE_FANIN);
        localparam int BASE_IN  = level_base(l - 1, LEVELS, TREE_FANIN);
        for (genvar j = 0; j < NODES; j++)
        begin : g_node
            logic [TREE_FANIN-1:0]           a_in;
            logic [TREE_FANIN-1:0]           h_in;
            logic [TREE_FANIN-1:0][IDXW-1:0] x_in;
            for (genvar k = 0; k < TREE_FANIN; k++)
            begin : g_child
                assign a_in[k] = node_alive[BASE_IN + TREE_FANIN * j + k];
                assign h_in[k] = node_hit[BASE_IN + TREE_FANIN * j + k];
                assign x_in[k] = node_idx[BASE_IN + TREE_FANIN * j + k];
            end
            lzse_node #(
                .IDXW (IDXW)
            ) u_node (
                .clk       (clk),
                .alive_in  (a_in),
                .hit_in    (h_in),
                .idx_in    (x_in),
                .alive_out (node_alive[BASE + j]),
                .hit_out   (node_hit[BASE + j]),
                .idx_out   (node_idx[BASE + j])
            );
        end
    end

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_take   = in_valid && in_ready;
    assign extend    = node_hit[ROOT] && (len_reg < MAX_LEN) && !last_reg;
    assign commit_go = (state_reg == ST_COMMIT)
                       && (extend || !out_valid_reg || out_ready);

    assign ctl = '{step: commit_go, extend: extend};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_take)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (cnt_reg == LAST_LVL)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        len_next = len_reg;
        if (commit_go)
        begin
            len_next = extend ? len_reg + 1'b1 : '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit_go && !extend)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= data_byte;
            last_reg <= last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit_go && !extend)
        begin
            offset_reg    <= (len_reg != '0) ? node_idx[ROOT][OFFSET_W-1:0] : '0;
            length_reg    <= len_reg;
            next_byte_reg <= byte_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign offset    = offset_reg;
    assign length    = length_reg;
    assign next_byte = next_byte_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lzse_cell.sv =====
// ----------------------------------------------------------------------------
// lzse_cell
// One window position: history byte, fill flag and live-candidate flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lzse_cell
    import lzse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctl_t         ctl,
    input  wire logic [BYTE_W-1:0] cmp_byte,
    input  wire logic [BYTE_W-1:0] prev_byte,
    input  wire logic              prev_filled,
    output logic      [BYTE_W-1:0] hist_byte,
    output logic                   filled,
    output logic                   alive,
    output logic                   hit
);

    logic [BYTE_W-1:0] hist_reg;
    logic              filled_reg;
    logic              alive_reg;
    logic              alive_next;

    assign hit        = alive_reg && (hist_reg == cmp_byte);
    assign alive_next = ctl.extend ? hit : prev_filled;

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            hist_reg <= prev_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
            alive_reg  <= 1'b0;
        end
        else if (ctl.step)
        begin
            filled_reg <= prev_filled;
            alive_reg  <= alive_next;
        end
    end

    assign hist_byte = hist_reg;
    assign filled    = filled_reg;
    assign alive     = alive_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lzse_node.sv =====
// ----------------------------------------------------------------------------
// lzse_node
// Registered tree node: highest live offset and any-hit over its children.
// ----------------------------------------------------------------------------
`default_nettype none

module lzse_node
    import lzse_pkg::*;
#(
    parameter int IDXW = OFFSET_W
)
(
    input  wire logic                                clk,
    input  wire logic [TREE_FANIN-1:0]               alive_in,
    input  wire logic [TREE_FANIN-1:0]               hit_in,
    input  wire logic [TREE_FANIN-1:0][IDXW-1:0]     idx_in,
    output logic                                     alive_out,
    output logic                                     hit_out,
    output logic      [IDXW-1:0]                     idx_out
);

    logic            alive_next;
    logic            hit_next;
    logic [IDXW-1:0] idx_next;
    logic            alive_reg;
    logic            hit_reg;
    logic [IDXW-1:0] idx_reg;

    // higher child wins
    always_comb
    begin
        alive_next = 1'b0;
        hit_next   = |hit_in;
        idx_next   = '0;
        for (int k = 0; k < TREE_FANIN; k++)
        begin
            if (alive_in[k])
            begin
                alive_next = 1'b1;
                idx_next   = idx_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        alive_reg <= alive_next;
        hit_reg   <= hit_next;
        idx_reg   <= idx_next;
    end

    assign alive_out = alive_reg;
    assign hit_out   = hit_reg;
    assign idx_out   = idx_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lzse_checker.sv =====
// ----------------------------------------------------------------------------
// lzse_checker
// Port-level checks for the LZ77 stream encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lzse_checker
    import lzse_pkg::*;
#(
    parameter int MAX_MATCH = DEF_MAX_MATCH
)
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic [BYTE_W-1:0]   data_byte,
    input wire logic                last,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [OFFSET_W-1:0] offset,
    input wire logic [LEN_W-1:0]    length,
    input wire logic [BYTE_W-1:0]   next_byte
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MATCH);

    // a waiting item keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(last))
        else $error("item changed while waiting");

    // a held token keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(offset)
            && $stable(length) && $stable(next_byte))
        else $error("token changed while stalled");

    // no offset without a match
    a_off_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (length == '0) |-> (offset == '0))
        else $error("offset set on a literal-only token");

    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (length <= MAX_LEN))
        else $error("match length above limit");

    // one item in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while previous item still in flight");

endmodule

bind lz77_stream_encoder_core lzse_checker #(
    .MAX_MATCH (MAX_MATCH)
) u_lzse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .offset    (offset),
    .length    (length),
    .next_byte (next_byte)
);

`default_nettype wire

// ===== sim/tb_lz77_stream_encoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_lz77_stream_encoder_core
// Self-checking testbench for the greedy LZ77 stream encoder.
// ----------------------------------------------------------------------------
// Feeds a byte stream built from back-copies, runs, literals and noise, with
// the last flag set at random segment ends. A software copy of the history
// window and live-offset set predicts each token, and every token from the
// block is checked field by field in order. Both handshakes idle at random,
// the output is held off for a long stretch and the input pauses to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lz77_stream_encoder_core;
    import lzse_pkg::*;

    localparam int HIST_DEPTH = DEF_WINDOW + 1;

    class token_scoreboard;
        typedef struct packed {
            logic [OFFSET_W-1:0] off;
            logic [LEN_W-1:0]    run;
            logic [BYTE_W-1:0]   lit;
        } token_t;

        logic [BYTE_W-1:0] hist [HIST_DEPTH];
        bit                alive [HIST_DEPTH];
        int unsigned       wr_ptr;
        int unsigned       seen;
        int unsigned       match_len;
        token_t            expected_tokens [$];
        int                errors;

        function new();
            wr_ptr    = 0;
            seen      = 0;
            match_len = 0;
            errors    = 0;
            foreach (alive[d]) alive[d] = 1'b0;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function void take_byte(input logic [BYTE_W-1:0] b, input logic fin);
            int unsigned top;
            bit          hit;
            token_t      tok;
            top = 0;
            hit = 1'b0;
            for (int d = 1; d <= int'(seen); d++) begin
                if (alive[d]) begin
                    top = d;
                    if (hist[(wr_ptr + HIST_DEPTH - d) % HIST_DEPTH] == b) hit = 1'b1;
                end
            end
            if (hit && match_len < DEF_MAX_MATCH && !fin) begin
                for (int d = 1; d <= int'(seen); d++) begin
                    if (alive[d] && hist[(wr_ptr + HIST_DEPTH - d) % HIST_DEPTH] != b)
                        alive[d] = 1'b0;
                end
                match_len++;
            end
            else begin
                tok.off = (match_len != 0) ? top[OFFSET_W-1:0] : '0;
                tok.run = match_len[LEN_W-1:0];
                tok.lit = b;
                expected_tokens = {expected_tokens, tok};
                match_len = 0;
            end
            hist[wr_ptr] = b;
            wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
            if (seen < DEF_WINDOW) seen++;
            if (match_len == 0) begin
                for (int d = 1; d <= DEF_WINDOW; d++) alive[d] = (d <= int'(seen));
            end
        endfunction

        function void check_token(input logic [OFFSET_W-1:0] off,
                                  input logic [LEN_W-1:0] run,
                                  input logic [BYTE_W-1:0] lit);
            token_t tok;
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token: got offset %0d length %0d byte 0x%02h",
                         $time, off, run, lit);
                errors++;
                return;
            end
            tok = expected_tokens.pop_front();
            if (off !== tok.off) begin
                $display("%0t: offset mismatch: expected %0d, actual %0d",
                         $time, tok.off, off);
                errors++;
            end
            if (run !== tok.run) begin
                $display("%0t: length mismatch: expected %0d, actual %0d",
                         $time, tok.run, run);
                errors++;
            end
            if (lit !== tok.lit) begin
                $display("%0t: next_byte mismatch: expected 0x%02h, actual 0x%02h",
                         $time, tok.lit, lit);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [BYTE_W-1:0]   data_byte;
    logic                last;
    logic                out_valid;
    logic                out_ready;
    logic [OFFSET_W-1:0] offset;
    logic [LEN_W-1:0]    length;
    logic [BYTE_W-1:0]   next_byte;

    token_scoreboard   sb = new();
    logic [BYTE_W-1:0] stream [$];
    int                bytes_sent = 0;
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    bit                hold_req = 1'b0;
    int                hold_cnt = 0;

    lz77_stream_encoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .offset    (offset),
        .length    (length),
        .next_byte (next_byte)
    );

    always #5 clk = ~clk;

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.take_byte(b, fin);
        stream = {stream, b};
        bytes_sent++;
    endtask

    // one stretch of stream: back-copy, run, literals or noise
    task automatic send_segment();
        logic [BYTE_W-1:0] seg [$];
        logic [BYTE_W-1:0] b;
        int                kind;
        int                n;
        int                back;
        int                span;
        kind = $urandom_range(99);
        if (kind < 45 && stream.size() > 0)
        begin
            span = (stream.size() < 2000) ? stream.size() : 2000;
            back = ($urandom_range(1)) ? $urandom_range(span, 1)
                                       : $urandom_range((span < 16) ? span : 16, 1);
            n = $urandom_range(40, 3);
            for (int i = 0; i < n; i++)
            begin
                if (back <= seg.size())
                    b = seg[seg.size() - back];
                else
                    b = stream[stream.size() - (back - seg.size())];
                if ($urandom_range(99) < 5) b = BYTE_W'($urandom_range(255));
                seg = {seg, b};
            end
        end
        else if (kind < 60)
        begin
            b = BYTE_W'($urandom_range(255));
            n = ($urandom_range(99) < 5) ? $urandom_range(300, 256) : $urandom_range(60, 2);
            repeat (n) seg = {seg, b};
        end
        else if (kind < 85)
        begin
            n = $urandom_range(8, 1);
            repeat (n)
            begin
                b = 8'h40 | BYTE_W'($urandom_range(3));
                seg = {seg, b};
            end
        end
        else
        begin
            n = $urandom_range(20, 1);
            repeat (n)
            begin
                b = BYTE_W'($urandom_range(255));
                seg = {seg, b};
            end
        end
        for (int i = 0; i < seg.size(); i++)
            send_byte(seg[i], (i == seg.size() - 1) && ($urandom_range(99) < 12));
    endtask

    task automatic send_random(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target) send_segment();
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready) sb.check_token(offset, length, next_byte);
        if (hold_cnt != 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_cnt  <= 400;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial
    begin
        #5000000;
        $display("tb_lz77_stream_encoder_core: FAIL");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = '0;
        last      = 1'b0;
        out_ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 29;
        rx_idle_pct = 61;

        // empty history, then overlapping run closed by a final byte
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // match that breaks on a literal; ties go to the largest offset
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h33, 1'b0);
        // final byte straight after a token
        send_byte(8'h00, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h33, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);

        // run long enough to hit the length limit
        for (int i = 0; i < 300; i++) send_byte(8'hA5, 1'b0);
        send_random(230);

        in_valid <= 1'b0;
        wait_drained();

        tx_idle_pct = 61;
        rx_idle_pct = 29;
        send_random(520);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        send_random(500);
        send_byte(8'h5A, 1'b1);
        in_valid <= 1'b0;

        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_lz77_stream_encoder_core: PASS");
        else
            $display("tb_lz77_stream_encoder_core: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
